// File: sv/linear_probe_hash_set_macros.svh
// assertion macros for the hash set
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lph assertion failed");

// next-cycle implication, disabled during reset
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lph assertion failed");

`endif

// File: sv/lph_pkg.sv
`timescale 1ns / 1ps
package lph_pkg;

  // slot count is a power of two so the home slot is the low key bits
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned SLOTS  = 1 << SLOT_W;
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned OUT_SLOT_W = 4;

  localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL    = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  typedef struct packed {
    logic              en;
    logic              key_en;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [1:0]        status;
  } lph_wr_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       status;
  } lph_rd_t;

endpackage

// File: sv/lph_store.sv
`timescale 1ns / 1ps
module lph_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lph_pkg::SLOT_W-1:0] rd_addr_i,
  input  lph_pkg::lph_wr_t           wr_i,
  output lph_pkg::lph_rd_t           rd_o
);

  logic [lph_pkg::KEY_W-1:0] key_mem [lph_pkg::SLOTS];
  logic [1:0]                stat_mem [lph_pkg::SLOTS];
  logic [lph_pkg::SLOTS-1:0] valid_q;

  logic [lph_pkg::KEY_W-1:0] key_rd_q;
  logic [1:0]                stat_rd_q;
  logic                      vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.key_en) begin
      key_mem[wr_i.addr] <= wr_i.key;
    end
    if (wr_i.en) begin
      stat_mem[wr_i.addr] <= wr_i.status;
    end
    key_rd_q  <= key_mem[rd_addr_i];
    stat_rd_q <= stat_mem[rd_addr_i];
  end

  // valid bits make every slot read as empty right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      vld_rd_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_o.key    = key_rd_q;
  assign rd_o.status = vld_rd_q ? stat_rd_q : lph_pkg::ST_EMPTY;

endmodule

// File: sv/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// a request probes 1 to SLOTS slots from its home slot on; its result is registered after the last probe step
// a new request is accepted only while busy is low, once the previous one has ended; one read per probe step
// a zero key or unused op code gives its result in the next cycle and busy stays low
// the result strobe lasts one cycle; the receiver cannot stall, so busy never waits on it
// reset is asynchronous and active low; slot status reads empty at once, no clearing pass
`include "linear_probe_hash_set_macros.svh"
module linear_probe_hash_set (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [lph_pkg::OP_W-1:0]       op_i,
  input  logic [lph_pkg::KEY_W-1:0]      key_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic                           stored_o,
  output logic                           full_res_o,
  output logic                           bad_key_o,
  output logic [lph_pkg::OUT_SLOT_W-1:0] slot_o
);

  typedef enum logic {S_IDLE, S_PROBE} state_e;

  localparam logic [lph_pkg::SLOT_W-1:0] LastCnt = lph_pkg::SLOT_W'(lph_pkg::SLOTS - 1);

  state_e                           state_q, state_d;
  logic [lph_pkg::OP_W-1:0]         op_q, op_d;
  logic [lph_pkg::KEY_W-1:0]        key_q, key_d;
  logic [lph_pkg::SLOT_W-1:0]       idx_q, idx_d;
  logic [lph_pkg::SLOT_W-1:0]       cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic                             found_q, found_d;
  logic                             stored_q, stored_d;
  logic                             full_q, full_d;
  logic                             bad_q, bad_d;
  logic [lph_pkg::OUT_SLOT_W-1:0]   slot_q, slot_d;

  logic [lph_pkg::SLOT_W-1:0]       rd_addr;
  lph_pkg::lph_wr_t                 wr;
  lph_pkg::lph_rd_t                 rd;
  logic                             hit, empty;

  lph_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  // read data belongs to idx_q during a probe
  assign hit   = (rd.status == lph_pkg::ST_USED) && (rd.key == key_q);
  assign empty = (rd.status == lph_pkg::ST_EMPTY);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    found_d  = 1'b0;
    stored_d = 1'b0;
    full_d   = 1'b0;
    bad_d    = 1'b0;
    slot_d   = '0;
    rd_addr  = key_i[lph_pkg::SLOT_W-1:0];
    wr       = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          key_d = key_i;
          idx_d = key_i[lph_pkg::SLOT_W-1:0];
          cnt_d = '0;
          if (key_i == '0) begin
            done_d = 1'b1;
            bad_d  = 1'b1;
          end else if (op_i == lph_pkg::OP_MEMBER || op_i == lph_pkg::OP_ADD ||
                       op_i == lph_pkg::OP_DEL) begin
            state_d = S_PROBE;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          found_d = 1'b1;
          slot_d  = lph_pkg::OUT_SLOT_W'(idx_q);
          if (op_q == lph_pkg::OP_DEL) begin
            wr.en     = 1'b1;
            wr.addr   = idx_q;
            wr.status = lph_pkg::ST_GONE;
          end
        end else if (empty) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          // the first empty slot on the path is where an add places the key
          if (op_q == lph_pkg::OP_ADD) begin
            wr.en     = 1'b1;
            wr.key_en = 1'b1;
            wr.addr   = idx_q;
            wr.key    = key_q;
            wr.status = lph_pkg::ST_USED;
            stored_d  = 1'b1;
            slot_d    = lph_pkg::OUT_SLOT_W'(idx_q);
          end
        end else if (cnt_q == LastCnt) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          full_d  = (op_q == lph_pkg::OP_ADD);
        end else begin
          idx_d   = idx_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= lph_pkg::OP_MEMBER;
      key_q    <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      stored_q <= 1'b0;
      full_q   <= 1'b0;
      bad_q    <= 1'b0;
      slot_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      found_q  <= found_d;
      stored_q <= stored_d;
      full_q   <= full_d;
      bad_q    <= bad_d;
      slot_q   <= slot_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign found_o    = found_q;
  assign stored_o   = stored_q;
  assign full_res_o = full_q;
  assign bad_key_o  = bad_q;
  assign slot_o     = slot_q;

  `LPH_ASSERT_NXT(a_bad_key_resp, clk_i, rst_ni, start_i && !busy_o && key_i == '0, done_o && bad_key_o)
  `LPH_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `LPH_ASSERT_IMP(a_stored_excl, clk_i, rst_ni, done_o && stored_o, !found_o && !full_res_o)
  `LPH_ASSERT_NXT(a_probe_ends, clk_i, rst_ni, busy_o && cnt_q == LastCnt, !busy_o && done_o)

endmodule
